@@ design/i2cmbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Command codes, widths and the result type shared by the engine modules.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	localparam int TICK_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int PHASE_W   = 5;
	localparam int BIT_IDX_W = 3;

	localparam logic [TICK_W-1:0]    PHASE_TICKS_RESET = 16'd10;
	localparam logic [BIT_IDX_W-1:0] LAST_BIT          = 3'd7;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	typedef struct packed {
		logic              scl;
		logic              sda;
		logic              busy;
		logic              done;
		logic [BYTE_W-1:0] rx_byte;
		logic              ack_received;
	} result_t;

endpackage

@@ design/i2cmbe_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine sequencer
// Holds the command state and advances it by one bus tick per accepted beat.
// ----------------------------------------------------------------------------
module i2cmbe_step
	import i2cmbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [TICK_W-1:0] phase_ticks,
	input  logic              cmd_valid,
	input  logic [1:0]        func,
	input  logic [BYTE_W-1:0] tx_byte,
	input  logic              ack_to_send,
	input  logic              sda_in,
	output result_t           result
);

	logic [1:0]           cmd_q, n_cmd;
	logic [PHASE_W-1:0]   phase_q, n_phase;
	logic [BIT_IDX_W-1:0] bit_q, n_bit;
	logic [TICK_W-1:0]    tick_q, n_tick;
	logic [BYTE_W-1:0]    shift_q, n_shift;
	logic                 pend_q, n_pend;
	logic                 scl_q, n_scl;
	logic                 sda_q, n_sda;
	logic                 active_q, n_active;
	logic [BYTE_W-1:0]    last_rx_q, n_last_rx;
	logic                 last_ack_q, n_last_ack;
	logic                 n_done;
	logic                 act;
	logic [PHASE_W-1:0]   last_phase;

	always_comb begin
		n_cmd      = cmd_q;
		n_phase    = phase_q;
		n_bit      = bit_q;
		n_tick     = tick_q;
		n_shift    = shift_q;
		n_pend     = pend_q;
		n_scl      = scl_q;
		n_sda      = sda_q;
		n_active   = active_q;
		n_last_rx  = last_rx_q;
		n_last_ack = last_ack_q;
		n_done     = 1'b0;
		act        = 1'b0;

		unique case (cmd_q)
			CMD_START: last_phase = 5'd3;
			CMD_STOP:  last_phase = 5'd2;
			default:   last_phase = 5'd6;
		endcase

		if (active_q) begin
			if (tick_q < phase_ticks) begin
				n_tick = tick_q + 1'b1;
			end else begin
				act = 1'b1;
				// Bit loops jump back into the sequence instead of moving on.
				priority if (cmd_q == CMD_WRITE && phase_q == 5'd2 && bit_q != LAST_BIT) begin
					n_bit   = bit_q + 1'b1;
					n_phase = '0;
				end else if (cmd_q == CMD_READ && phase_q == 5'd3 && bit_q != LAST_BIT) begin
					n_bit   = bit_q + 1'b1;
					n_phase = 5'd1;
				end else if (phase_q >= last_phase) begin
					act      = 1'b0;
					n_active = 1'b0;
					n_done   = 1'b1;
					if (cmd_q == CMD_WRITE) begin
						n_last_ack = pend_q;
					end else if (cmd_q == CMD_READ) begin
						n_last_rx = shift_q;
					end
				end else begin
					n_phase = phase_q + 1'b1;
				end
				if (act) begin
					n_tick = 16'd1;
				end
			end
		end else if (cmd_valid) begin
			act      = 1'b1;
			n_cmd    = func;
			n_phase  = '0;
			n_bit    = '0;
			n_tick   = 16'd1;
			n_shift  = (func == CMD_WRITE) ? tx_byte : '0;
			n_pend   = (func == CMD_READ) ? ack_to_send : 1'b0;
			n_active = 1'b1;
		end

		// The action of a phase happens on its first tick.
		if (act) begin
			unique case (n_cmd)
				CMD_START: begin
					priority if (n_phase == 5'd0) n_sda = 1'b1;
					else if (n_phase == 5'd1) n_scl = 1'b1;
					else if (n_phase == 5'd2) n_sda = 1'b0;
					else n_scl = 1'b0;
				end
				CMD_STOP: begin
					priority if (n_phase == 5'd0) n_sda = 1'b0;
					else if (n_phase == 5'd1) n_scl = 1'b1;
					else n_sda = 1'b1;
				end
				CMD_WRITE: begin
					priority if (n_phase == 5'd0) n_sda = n_shift[LAST_BIT - n_bit];
					else if (n_phase == 5'd1) n_scl = 1'b1;
					else if (n_phase == 5'd2) n_scl = 1'b0;
					else if (n_phase == 5'd3) n_sda = 1'b1;
					else if (n_phase == 5'd4) n_scl = 1'b1;
					else if (n_phase == 5'd5) n_pend = sda_in;
					else n_scl = 1'b0;
				end
				default: begin
					priority if (n_phase == 5'd0) n_sda = 1'b1;
					else if (n_phase == 5'd1) n_scl = 1'b1;
					else if (n_phase == 5'd2) n_shift = {n_shift[BYTE_W-2:0], sda_in};
					else if (n_phase == 5'd3) n_scl = 1'b0;
					else if (n_phase == 5'd4) n_sda = n_pend;
					else if (n_phase == 5'd5) n_scl = 1'b1;
					else n_scl = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= CMD_START;
			phase_q    <= '0;
			bit_q      <= '0;
			tick_q     <= '0;
			shift_q    <= '0;
			pend_q     <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			active_q   <= 1'b0;
			last_rx_q  <= '0;
			last_ack_q <= 1'b0;
		end else if (step) begin
			cmd_q      <= n_cmd;
			phase_q    <= n_phase;
			bit_q      <= n_bit;
			tick_q     <= n_tick;
			shift_q    <= n_shift;
			pend_q     <= n_pend;
			scl_q      <= n_scl;
			sda_q      <= n_sda;
			active_q   <= n_active;
			last_rx_q  <= n_last_rx;
			last_ack_q <= n_last_ack;
		end
	end

	assign result.scl          = n_scl;
	assign result.sda          = n_sda;
	assign result.busy         = n_active;
	assign result.done         = n_done;
	assign result.rx_byte      = n_last_rx;
	assign result.ack_received = n_last_ack;

endmodule

@@ design/i2cmbe_obuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine result buffer
// Output register with a skid stage, so one more result is taken while the
// output stalls; push_ready drops while the skid stage holds a result.
// ----------------------------------------------------------------------------
module i2cmbe_obuf
	import i2cmbe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    push_ready,
	input  result_t push_data,
	output logic    pop_valid,
	input  logic    pop_ready,
	output result_t pop_data
);

	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    pop;

	assign pop        = out_valid_q & pop_ready;
	assign push_ready = !skid_valid_q;
	assign pop_valid  = out_valid_q;
	assign pop_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push && !skid_valid_q) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !skid_valid_q) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

endmodule

@@ design/i2c_master_byte_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine
// Open-drain I2C master stepping start, stop, write and read sequences.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  cfg      cfg_valid/cfg_ready  cfg_data (phase_ticks)
//  in       in_valid/in_ready    cmd_valid, func, tx_byte, ack_to_send, sda_in
//  out      out_valid/out_ready  scl_out, sda_out, busy_res, done_res,
//                                rx_byte, ack_received
//
// Each input beat is one bus tick; the sequencer state advances at the edge
// the beat is accepted, its result is registered at that same edge in the
// output register, or the skid stage if it stalls, then offered on out_valid.
// One beat per cycle is sustained while out_ready is high; a stalled result
// sits in the output register while one more beat enters the skid stage.
// Reset leaves both lines released, the engine idle and phase_ticks at 10.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
	import i2cmbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TICK_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd_valid,
	input  logic [1:0]        func,
	input  logic [BYTE_W-1:0] tx_byte,
	input  logic              ack_to_send,
	input  logic              sda_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              scl_out,
	output logic              sda_out,
	output logic              busy_res,
	output logic              done_res,
	output logic [BYTE_W-1:0] rx_byte,
	output logic              ack_received
);

	logic [TICK_W-1:0] phase_ticks_q;
	logic              step;
	result_t           step_res;
	result_t           out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
		end else if (cfg_valid) begin
			phase_ticks_q <= cfg_data;
		end
	end

	assign step = in_valid & in_ready;

	i2cmbe_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.phase_ticks (phase_ticks_q),
		.cmd_valid   (cmd_valid),
		.func        (func),
		.tx_byte     (tx_byte),
		.ack_to_send (ack_to_send),
		.sda_in      (sda_in),
		.result      (step_res)
	);

	i2cmbe_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (step),
		.push_ready (in_ready),
		.push_data  (step_res),
		.pop_valid  (out_valid),
		.pop_ready  (out_ready),
		.pop_data   (out_res)
	);

	assign scl_out      = out_res.scl;
	assign sda_out      = out_res.sda;
	assign busy_res     = out_res.busy;
	assign done_res     = out_res.done;
	assign rx_byte      = out_res.rx_byte;
	assign ack_received = out_res.ack_received;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Streams bus ticks into the engine under bursty input and stalled output,
// predicts the pin levels, busy, done, received byte and write acknowledge of
// every tick, and compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module tb;
	import i2cmbe_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int END_CYCLES  = 20;

	typedef struct packed {
		logic              cmd_valid;
		logic [1:0]        func;
		logic [BYTE_W-1:0] tx_byte;
		logic              ack_to_send;
		logic              sda_in;
	} bus_tick_t;

	typedef enum int {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_mode_t;
	typedef enum int {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_SPARSE} ready_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [TICK_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              cmd_valid = 1'b0;
	logic [1:0]        func = CMD_START;
	logic [BYTE_W-1:0] tx_byte = '0;
	logic              ack_to_send = 1'b0;
	logic              sda_in = 1'b1;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              scl_out;
	logic              sda_out;
	logic              busy_res;
	logic              done_res;
	logic [BYTE_W-1:0] rx_byte;
	logic              ack_received;

	i2c_master_byte_engine u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd_valid    (cmd_valid),
		.func         (func),
		.tx_byte      (tx_byte),
		.ack_to_send  (ack_to_send),
		.sda_in       (sda_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.scl_out      (scl_out),
		.sda_out      (sda_out),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.rx_byte      (rx_byte),
		.ack_received (ack_received)
	);

	always #2 clk = ~clk;

	bus_tick_t tick_queue[$];
	result_t   expected_pins[$];
	int        ticks_queued = 0;
	int        cycle_count = 0;
	int        fail_count = 0;
	int        beats_checked = 0;
	int        cmd_count = 0;
	int        ignored_count = 0;
	int        done_count = 0;

	// Engine state as the predictor sees it.
	logic [TICK_W-1:0]    eng_phase_ticks = PHASE_TICKS_RESET;
	logic [1:0]           eng_cmd = CMD_START;
	logic [PHASE_W-1:0]   eng_phase = '0;
	logic [BIT_IDX_W-1:0] eng_bit = '0;
	logic [TICK_W-1:0]    eng_ticks = '0;
	logic [BYTE_W-1:0]    eng_shift = '0;
	logic                 eng_ack = 1'b0;
	logic                 eng_scl = 1'b1;
	logic                 eng_sda = 1'b1;
	logic                 eng_busy = 1'b0;
	logic [BYTE_W-1:0]    eng_last_rx = '0;
	logic                 eng_last_ack = 1'b0;

	function automatic void apply_phase(input logic sda);
		case (eng_cmd)
			CMD_START: begin
				case (eng_phase)
					0: eng_sda = 1'b1;
					1: eng_scl = 1'b1;
					2: eng_sda = 1'b0;
					default: eng_scl = 1'b0;
				endcase
			end
			CMD_STOP: begin
				case (eng_phase)
					0: eng_sda = 1'b0;
					1: eng_scl = 1'b1;
					default: eng_sda = 1'b1;
				endcase
			end
			CMD_WRITE: begin
				case (eng_phase)
					0: eng_sda = eng_shift[LAST_BIT - eng_bit];
					1: eng_scl = 1'b1;
					2: eng_scl = 1'b0;
					3: eng_sda = 1'b1;
					4: eng_scl = 1'b1;
					5: eng_ack = sda;
					default: eng_scl = 1'b0;
				endcase
			end
			default: begin
				case (eng_phase)
					0: eng_sda = 1'b1;
					1: eng_scl = 1'b1;
					2: eng_shift = {eng_shift[BYTE_W-2:0], sda};
					3: eng_scl = 1'b0;
					4: eng_sda = eng_ack;
					5: eng_scl = 1'b1;
					default: eng_scl = 1'b0;
				endcase
			end
		endcase
	endfunction

	// Returns 0 once the last phase of the sequence has been held.
	function automatic bit advance_phase();
		logic [PHASE_W-1:0] last_phase;
		last_phase = (eng_cmd == CMD_START) ? 5'd3 : (eng_cmd == CMD_STOP) ? 5'd2 : 5'd6;
		if (eng_cmd == CMD_WRITE && eng_phase == 5'd2 && eng_bit != LAST_BIT) begin
			eng_bit++;
			eng_phase = 5'd0;
			return 1'b1;
		end
		if (eng_cmd == CMD_READ && eng_phase == 5'd3 && eng_bit != LAST_BIT) begin
			eng_bit++;
			eng_phase = 5'd1;
			return 1'b1;
		end
		if (eng_phase >= last_phase)
			return 1'b0;
		eng_phase++;
		return 1'b1;
	endfunction

	function automatic result_t predict_pins(input bus_tick_t t);
		result_t r;
		logic    done;
		done = 1'b0;
		if (eng_busy) begin
			if (t.cmd_valid)
				ignored_count++;
			if (eng_ticks < eng_phase_ticks) begin
				eng_ticks++;
			end else if (advance_phase()) begin
				eng_ticks = 16'd1;
				apply_phase(t.sda_in);
			end else begin
				eng_busy = 1'b0;
				done = 1'b1;
				done_count++;
				if (eng_cmd == CMD_WRITE)
					eng_last_ack = eng_ack;
				else if (eng_cmd == CMD_READ)
					eng_last_rx = eng_shift;
			end
		end else if (t.cmd_valid) begin
			eng_cmd   = t.func;
			eng_phase = '0;
			eng_bit   = '0;
			eng_ticks = 16'd1;
			eng_shift = (t.func == CMD_WRITE) ? t.tx_byte : '0;
			eng_ack   = (t.func == CMD_READ) ? t.ack_to_send : 1'b0;
			eng_busy  = 1'b1;
			cmd_count++;
			apply_phase(t.sda_in);
		end
		r.scl          = eng_scl;
		r.sda          = eng_sda;
		r.busy         = eng_busy;
		r.done         = done;
		r.rx_byte      = eng_last_rx;
		r.ack_received = eng_last_ack;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic logic pick_sda(input sda_mode_t mode);
		case (mode)
			SDA_HIGH: return 1'b1;
			SDA_LOW:  return 1'b0;
			default:  return 1'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic push_tick(input logic cv, input logic [1:0] f, input logic [7:0] b,
			input logic a, input logic s);
		tick_queue.push_back({cv, f, b, a, s});
		ticks_queued++;
	endtask

	// Ticks with random command fields; with allow_cmd some carry a command, and
	// one that lands while busy or on the done tick must be ignored.
	task automatic push_filler(input int n, input sda_mode_t mode, input bit allow_cmd);
		repeat (n) begin
			push_tick(allow_cmd && ($urandom_range(0, 3) == 0), 2'($urandom_range(0, 3)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_sda(mode));
		end
	endtask

	task automatic push_command(input logic [1:0] f, input logic [7:0] b, input logic a,
			input int ticks_per_phase, input sda_mode_t mode);
		int phases;
		phases = (f == CMD_START) ? 4 : (f == CMD_STOP) ? 3 : 28;
		push_tick(1'b1, f, b, a, pick_sda(mode));
		// The rest of the sequence plus the done tick.
		push_filler(phases * (ticks_per_phase == 0 ? 1 : ticks_per_phase), mode, 1'b1);
	endtask

	task automatic push_transactions(input int ticks_per_phase, input int budget);
		int stop_at;
		int n;
		stop_at = ticks_queued + budget;
		while (ticks_queued < stop_at) begin
			if ($urandom_range(0, 7) == 0) begin
				push_filler($urandom_range(10, 30), SDA_RANDOM, 1'b1);
			end else begin
				push_command(CMD_START, 8'h00, 1'b0, ticks_per_phase, SDA_RANDOM);
				push_command(CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, ticks_per_phase,
					SDA_RANDOM);
				n = $urandom_range(1, 3);
				repeat (n) begin
					push_filler($urandom_range(0, 2), SDA_RANDOM, 1'b0);
					if ($urandom_range(0, 1) == 0)
						push_command(CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0,
							ticks_per_phase, SDA_RANDOM);
					else
						push_command(CMD_READ, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), ticks_per_phase, SDA_RANDOM);
				end
				push_command(CMD_STOP, 8'h00, 1'b0, ticks_per_phase, SDA_RANDOM);
				push_filler($urandom_range(0, 3), SDA_RANDOM, 1'b0);
			end
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (tick_queue.size() != 0 || in_valid || expected_pins.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_phase_ticks(input logic [TICK_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		eng_phase_ticks = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------- input driver ----------------

	bit in_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_pins.push_back(predict_pins({cmd_valid, func, tx_byte, ack_to_send,
				sda_in}));
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			in_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (tick_queue.size() != 0) begin
				{cmd_valid, func, tx_byte, ack_to_send, sda_in} <= tick_queue.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------- output stall pattern ----------------

	ready_mode_t ready_mode = READY_ALWAYS;
	int          ready_left = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				ready_left = $urandom_range(20, 120);
			end else begin
				ready_left--;
			end
			case (ready_mode)
				READY_ALWAYS:   out_ready <= 1'b1;
				READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
				READY_PERIODIC: out_ready <= (cycle_count % 4) != 0;
				default:        out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// ---------------- result monitor ----------------

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pins.size() == 0) begin
				$error("result beat with no prediction pending");
				fail_count++;
			end else begin
				want = expected_pins.pop_front();
				check_field("scl_out", want.scl, scl_out);
				check_field("sda_out", want.sda, sda_out);
				check_field("busy_res", want.busy, busy_res);
				check_field("done_res", want.done, done_res);
				check_field("rx_byte", want.rx_byte, rx_byte);
				check_field("ack_received", want.ack_received, ack_received);
				beats_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d predictions pending", cycle_count,
				expected_pins.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------- test sequence ----------------

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset value: both lines released while idle.
		push_filler(3, SDA_RANDOM, 1'b0);
		wait_drained();

		// A zero length behaves as one tick per phase. Byte and ack extremes.
		write_phase_ticks(16'd0);
		push_command(CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
		push_command(CMD_WRITE, 8'hFF, 1'b0, 0, SDA_HIGH);
		push_command(CMD_WRITE, 8'h00, 1'b0, 0, SDA_LOW);
		push_command(CMD_READ, 8'h00, 1'b1, 0, SDA_HIGH);
		push_command(CMD_READ, 8'hFF, 1'b0, 0, SDA_LOW);
		push_command(CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
		wait_drained();

		// Largest length, idle ticks only.
		write_phase_ticks(16'hFFFF);
		push_filler(4, SDA_RANDOM, 1'b0);
		wait_drained();

		// Shorten the phase length in the middle of a write; the held phase
		// already reaches the new count and must advance on the next tick.
		write_phase_ticks(16'd3);
		push_tick(1'b1, CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
		push_filler(12, SDA_RANDOM, 1'b1);
		wait_drained();
		write_phase_ticks(16'd1);
		push_filler(40, SDA_RANDOM, 1'b1);
		wait_drained();

		write_phase_ticks(16'd1);
		push_transactions(1, 1);
		wait_drained();
		write_phase_ticks(16'd2);
		push_transactions(2, 1);
		wait_drained();
		write_phase_ticks(16'd0);
		push_transactions(0, 1);
		wait_drained();

		repeat (END_CYCLES) @(posedge clk);
		$display("checked %0d result beats: %0d commands run, %0d done pulses,",
			beats_checked, cmd_count, done_count);
		$display("%0d commands offered while busy; phase lengths 0, 1, 2, 3, 10 and 65535",
			ignored_count);
		if (fail_count == 0 && expected_pins.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d predictions left over", fail_count,
				expected_pins.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
